>>> src/qnl_pkg.sv
// ----------------------------------------------------------------------------
// qnl_pkg: quaternion nlerp constants and widths
// Fixed-point constants of the reciprocal square root approximation and the
// internal word widths shared by the top level and the refinement pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qnl_pkg;

  // Internal widths
  localparam int BW    = 19;  // blended component, signed
  localparam int SQW   = 36;  // squared component, unsigned
  localparam int MW    = 37;  // squared magnitude, unsigned Q.28
  localparam int DW    = 38;  // magnitude minus center, signed
  localparam int DLW   = 18;  // low split of DW for the first-guess product
  localparam int V0W   = 34;  // first guess, signed Q.24, full range
  localparam int VRW   = 28;  // factor inside a refinement step, signed Q.24
  localparam int MRW   = 29;  // magnitude inside a refinement step, signed
  localparam int PW    = 29;  // v*v, signed Q.24
  localparam int TW    = 30;  // v*v*m, signed Q.24
  localparam int QW    = 32;  // slope term, signed Q.24

  localparam int REFINE_LAT = 4;

  // Approximation constants
  localparam logic [31:0]        C0_Q28 = 32'd257447311;
  localparam logic signed [25:0] C0_Q24 = 26'sd16090457;
  localparam logic signed [24:0] C1_Q24 = 25'sd8934136;
  localparam logic signed [25:0] C2_Q24 = 26'sd17136836;
  localparam logic [31:0]        T1_Q28 = 32'd245675346;
  localparam logic [31:0]        T2_Q28 = 32'd175052049;

endpackage

`default_nettype wire

>>> src/qnl_refine.sv
// ----------------------------------------------------------------------------
// qnl_refine: one refinement step of the reciprocal square root
// Four-stage pipeline computing v * g(v*v*m), where g is the linear guess.
// ----------------------------------------------------------------------------
`default_nettype none

module qnl_refine import qnl_pkg::*; (
  input  logic                  clk,
  input  logic signed [VRW-1:0] v_in,
  input  logic signed [MRW-1:0] m_in,
  output logic signed [VRW-1:0] v_out
);

  localparam int EW  = TW + 1;
  localparam int EQW = EW + $bits(C1_Q24);

  logic signed [2*VRW-1:0] vv;
  logic signed [PW-1:0]    pa;
  logic signed [MRW-1:0]   ma;
  logic signed [VRW-1:0]   va;

  logic signed [PW+MRW-1:0] pm;
  logic signed [TW-1:0]     tb;
  logic signed [VRW-1:0]    vb;

  logic signed [EW-1:0]  e;
  logic signed [EQW-1:0] eq;
  logic signed [QW-1:0]  qc;
  logic signed [VRW-1:0] vc;

  logic signed [VRW-1:0]   f;
  logic signed [2*VRW-1:0] vf;

  // Stage A: square the factor
  assign vv = v_in * v_in;

  always_ff @(posedge clk) begin
    pa <= PW'((vv + (2*VRW)'(1 << 23)) >>> 24);
    ma <= m_in;
    va <= v_in;
  end

  // Stage B: scale by magnitude
  assign pm = pa * ma;

  always_ff @(posedge clk) begin
    tb <= TW'((pm + (PW+MRW)'(1 << 27)) >>> 28);
    vb <= va;
  end

  // Stage C: slope term of the linear guess
  assign e  = EW'(tb) - EW'(C0_Q24);
  assign eq = e * C1_Q24;

  always_ff @(posedge clk) begin
    qc <= QW'((eq + EQW'(1 << 23)) >>> 24);
    vc <= vb;
  end

  // Stage D: apply the correction factor
  assign f  = VRW'((QW+1)'(C2_Q24) - (QW+1)'(qc));
  assign vf = vc * f;

  always_ff @(posedge clk) begin
    v_out <= VRW'((vf + (2*VRW)'(1 << 23)) >>> 24);
  end

endmodule

`default_nettype wire

>>> src/quaternion_nlerp_rsqrt_approx_unit.sv
// ----------------------------------------------------------------------------
// quaternion_nlerp_rsqrt_approx_unit: normalized quaternion blend
// Blends two Q2.14 quaternions by a ratio and normalizes the result with a
// refined linear approximation of the reciprocal square root.
// ----------------------------------------------------------------------------
// Usage:
//   Drive ratio, first_* and second_* with start high. A transaction is taken
//   at each rising edge where start is high and busy is low. busy is low at
//   all times outside reset, so a new transaction can enter every cycle.
//   Each result appears on out_x..out_w for one cycle with done high, and
//   results leave in the same order in which their transactions were taken.
//   Throughput is one transaction per cycle; the latency is set by the
//   multiply chain: blend, square, sum, first guess, two four-stage
//   refinement steps and the final scaling, each multiplier followed by a
//   register.
//   Both refinement steps always run; the magnitude thresholds only select
//   which factor scales the output.
//   Synchronous reset drops all transactions in flight and holds busy high
//   while asserted. The receiver cannot stall; results are not held.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_nlerp_rsqrt_approx_unit import qnl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [14:0]        ratio,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] first_z,
  input  logic signed [15:0] first_w,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic signed [15:0] second_z,
  input  logic signed [15:0] second_w,
  output logic               done,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w
);

  localparam int PRE_N   = 6;
  localparam int SIDE_N  = 2 * REFINE_LAT + 1;
  localparam int LATENCY = PRE_N + SIDE_N + 2;
  localparam int PLW     = BW + 17;
  localparam int PHW     = BW + V0W - 16;
  localparam int FW      = BW + V0W + 1;
  localparam int GW      = 63;

  typedef struct packed {
    logic [3:0][BW-1:0]    b;
    logic signed [V0W-1:0] v0;
    logic signed [VRW-1:0] v1;
    logic signed [MRW-1:0] m;
    logic                  le_t1;
    logic                  le_t2;
  } side_t;

  function automatic logic signed [15:0] sat16(input logic signed [FW-1:0] x);
    logic signed [15:0] r;
    if (x > FW'(32767)) begin
      r = 16'sh7fff;
    end else if (x < -FW'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = 16'(x);
    end
    return r;
  endfunction

  logic signed [15:0] first_v  [4];
  logic signed [15:0] second_v [4];

  // Stage 1: blend products
  logic               s1_valid;
  logic signed [16:0] diff    [4];
  logic signed [32:0] prod    [4];
  logic signed [32:0] prod_s1 [4];
  logic signed [15:0] a_s1    [4];

  // Stage 2: blended components
  logic                 s2_valid;
  logic signed [32:0]   blend_rnd [4];
  logic signed [BW-1:0] b_s2      [4];

  // Stage 3: squares
  logic                   s3_valid;
  logic signed [2*BW-1:0] sq_full [4];
  logic [SQW-1:0]         sq_s3   [4];
  logic signed [BW-1:0]   b_s3    [4];

  // Stage 4: magnitude
  logic                 s4_valid;
  logic [MW-1:0]        m_s4;
  logic signed [BW-1:0] b_s4 [4];

  // Stage 5: centered magnitude and thresholds
  logic                  s5_valid;
  logic signed [DW-1:0]  d_s5;
  logic signed [MRW-1:0] m_s5;
  logic                  le_t1_s5;
  logic                  le_t2_s5;
  logic signed [BW-1:0]  b_s5 [4];

  // Stage 6: first-guess partial products
  logic                              s6_valid;
  logic signed [DW-DLW-1:0]          dh;
  logic signed [DLW:0]               dl;
  logic signed [DLW+$bits(C1_Q24):0] ppl;
  logic signed [DW-DLW+$bits(C1_Q24)-1:0] pph;
  logic signed [DLW+$bits(C1_Q24):0] ppl_s6;
  logic signed [DW-DLW+$bits(C1_Q24)-1:0] pph_s6;
  logic signed [MRW-1:0]             m_s6;
  logic                              le_t1_s6;
  logic                              le_t2_s6;
  logic signed [BW-1:0]              b_s6 [4];

  // Sideband line across the refinement steps
  logic signed [GW-1:0]  gp_sum;
  side_t                 side_next;
  side_t                 side_mid;
  side_t                 side_q [SIDE_N];
  logic [SIDE_N-1:0]     side_valid;
  logic signed [VRW-1:0] v1;
  logic signed [VRW-1:0] v2;

  // Final scaling
  logic                  f1_valid;
  logic signed [V0W-1:0] vsel;
  logic signed [PLW-1:0] pl    [4];
  logic signed [PHW-1:0] ph    [4];
  logic signed [PLW-1:0] pl_f1 [4];
  logic signed [PHW-1:0] ph_f1 [4];
  logic signed [FW-1:0]  scaled [4];

  assign busy = rst;

  assign first_v[0]  = first_x;
  assign first_v[1]  = first_y;
  assign first_v[2]  = first_z;
  assign first_v[3]  = first_w;
  assign second_v[0] = second_x;
  assign second_v[1] = second_y;
  assign second_v[2] = second_z;
  assign second_v[3] = second_w;

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      s5_valid   <= 1'b0;
      s6_valid   <= 1'b0;
      side_valid <= '0;
      f1_valid   <= 1'b0;
      done       <= 1'b0;
    end else begin
      s1_valid   <= start && !busy;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      s4_valid   <= s3_valid;
      s5_valid   <= s4_valid;
      s6_valid   <= s5_valid;
      side_valid <= {side_valid[SIDE_N-2:0], s6_valid};
      f1_valid   <= side_valid[SIDE_N-1];
      done       <= f1_valid;
    end
  end

  // Stages 1 to 3
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      diff[i]      = 17'(second_v[i]) - 17'(first_v[i]);
      prod[i]      = diff[i] * $signed({1'b0, ratio});
      blend_rnd[i] = (prod_s1[i] + 33'(1 << 13)) >>> 14;
      sq_full[i]   = b_s2[i] * b_s2[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      prod_s1[i] <= prod[i];
      a_s1[i]    <= first_v[i];
      b_s2[i]    <= BW'(a_s1[i]) + BW'(blend_rnd[i]);
      sq_s3[i]   <= SQW'(sq_full[i]);
      b_s3[i]    <= b_s2[i];
      b_s4[i]    <= b_s3[i];
      b_s5[i]    <= b_s4[i];
      b_s6[i]    <= b_s5[i];
    end
  end

  // Stages 4 to 6
  assign dh  = d_s5[DW-1:DLW];
  assign dl  = $signed({1'b0, d_s5[DLW-1:0]});
  assign ppl = dl * C1_Q24;
  assign pph = dh * C1_Q24;

  always_ff @(posedge clk) begin
    m_s4     <= MW'(sq_s3[0]) + MW'(sq_s3[1]) + MW'(sq_s3[2]) + MW'(sq_s3[3]);
    d_s5     <= DW'(m_s4) - DW'(C0_Q28);
    m_s5     <= $signed(m_s4[MRW-1:0]);
    le_t1_s5 <= m_s4 <= MW'(T1_Q28);
    le_t2_s5 <= m_s4 <= MW'(T2_Q28);
    ppl_s6   <= ppl;
    pph_s6   <= pph;
    m_s6     <= m_s5;
    le_t1_s6 <= le_t1_s5;
    le_t2_s6 <= le_t2_s5;
  end

  // First guess, then enter the sideband line
  assign gp_sum = (GW'(pph_s6) <<< DLW) + GW'(ppl_s6) + GW'(1 << 27);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      side_next.b[i] = b_s6[i];
    end
    side_next.v0    = V0W'(GW'(C2_Q24) - (gp_sum >>> 28));
    side_next.v1    = '0;
    side_next.m     = m_s6;
    side_next.le_t1 = le_t1_s6;
    side_next.le_t2 = le_t2_s6;
  end

  // catch the first refined factor as its transaction passes
  always_comb begin
    side_mid    = side_q[REFINE_LAT];
    side_mid.v1 = v1;
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side_next;
    for (int k = 1; k < SIDE_N; k++) begin
      if (k == REFINE_LAT + 1) begin
        side_q[k] <= side_mid;
      end else begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  qnl_refine u_refine_1 (
    .clk   (clk),
    .v_in  (VRW'(side_q[0].v0)),
    .m_in  (side_q[0].m),
    .v_out (v1)
  );

  qnl_refine u_refine_2 (
    .clk   (clk),
    .v_in  (v1),
    .m_in  (side_q[REFINE_LAT].m),
    .v_out (v2)
  );

  // Final scaling: pick the factor, split it, multiply
  always_comb begin
    if (side_q[SIDE_N-1].le_t2) begin
      vsel = V0W'(v2);
    end else if (side_q[SIDE_N-1].le_t1) begin
      vsel = V0W'(side_q[SIDE_N-1].v1);
    end else begin
      vsel = side_q[SIDE_N-1].v0;
    end
    for (int i = 0; i < 4; i++) begin
      pl[i]     = $signed(side_q[SIDE_N-1].b[i]) * $signed({1'b0, vsel[15:0]});
      ph[i]     = $signed(side_q[SIDE_N-1].b[i]) * $signed(vsel[V0W-1:16]);
      scaled[i] = ((FW'(ph_f1[i]) <<< 16) + FW'(pl_f1[i]) + FW'(1 << 23)) >>> 24;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pl_f1[i] <= pl[i];
      ph_f1[i] <= ph[i];
    end
    out_x <= sat16(scaled[0]);
    out_y <= sat16(scaled[1]);
    out_z <= sat16(scaled[2]);
    out_w <= sat16(scaled[3]);
  end

`ifndef SYNTHESIS
  a_done_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without a transaction taken %0d cycles before", LATENCY);

  a_transaction_completes: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("transaction taken but no result after %0d cycles", LATENCY);

  a_thresholds_nested: assert property (@(posedge clk) disable iff (rst)
    (side_valid[0] && side_q[0].le_t2) |-> side_q[0].le_t1)
    else $error("second threshold met without the first");

  a_refined_positive: assert property (@(posedge clk) disable iff (rst)
    (side_valid[SIDE_N-1] && side_q[SIDE_N-1].le_t1) |-> (side_q[SIDE_N-1].v1 > 0))
    else $error("refined factor out of range");
`endif

endmodule

`default_nettype wire
